[design/bloom_filter_word_set_defines.svh]
// Assertion macros shared by the bloom filter word set checker.
`ifndef BLOOM_FILTER_WORD_SET_DEFINES_SVH
`define BLOOM_FILTER_WORD_SET_DEFINES_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is held.
`define BFWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define BFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bfws_pkg.sv]
// Package: types, codes and constants of the bloom filter word set.
package bfws_pkg;

    // Width of the hashed bit index (log2 of the bit store size)
    localparam int HASH_BITS_DEFAULT = 16;
    localparam int COUNT_W           = 32;
    localparam int QUEUE_DEPTH       = 4;

    // Hash seeds and special bytes
    localparam logic [31:0] SEED_A     = 32'd5381;
    localparam logic [31:0] SEED_B     = 32'd0;
    localparam logic [7:0]  BYTE_LF    = 8'h0A;
    localparam logic [7:0]  BYTE_CR    = 8'h0D;

    // Input item kinds
    localparam logic [1:0]  KIND_CLEAR  = 2'd0;
    localparam logic [1:0]  KIND_LOAD   = 2'd1;
    localparam logic [1:0]  KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic               found_valid;
        logic [COUNT_W-1:0] word_count;
    } out_item_t;

    // Operations handed from the front part to the back part
    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_INSERT,
        OP_LOOKUP
    } op_t;

    // Back part sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SET_B,
        ST_LOOK,
        ST_SWEEP
    } back_state_t;

endpackage

[design/bloom_filter_word_set.sv]
// Bloom filter word set: front hashing stage, operation queue, bit store back end.
// Throughput: one byte per cycle while the queue has room. The back end takes a plain byte
// in ST_IDLE, a line insert as two writes on the single store write port (ST_IDLE, ST_SET_B),
// a lookup as registered store reads then a result (ST_LOOK). A clear item holds the back end
// while it sweeps the store. Results come through the queue and the result register.
// Reset (aresetn low, synchronous) clears control state, then a sweep zeroes the bit store;
// s_ready stays low until the sweep is done.
module bloom_filter_word_set #(
    parameter int HASH_BITS = bfws_pkg::HASH_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfws_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfws_pkg::out_item_t  m_item
);
    import bfws_pkg::*;

    localparam int OpW    = $bits(op_t);
    localparam int QWidth = OpW + 2 * HASH_BITS;

    logic                 push;
    op_t                  push_op;
    logic [HASH_BITS-1:0] push_ha, push_hb;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [QWidth-1:0]    q_data;
    logic                 init_done;

    bfws_front #(
        .HASH_BITS(HASH_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .init_done (init_done),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op),
        .push_ha   (push_ha),
        .push_hb   (push_hb)
    );

    bfws_queue #(
        .WIDTH(QWidth),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_op, push_ha, push_hb}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    bfws_back #(
        .HASH_BITS(HASH_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_op      (op_t'(q_data[QWidth-1 -: OpW])),
        .q_ha      (q_data[2*HASH_BITS-1 -: HASH_BITS]),
        .q_hb      (q_data[HASH_BITS-1:0]),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

[design/bfws_front.sv]
// Front part: accepts bytes, runs the line and query hashes, issues operations.
module bfws_front #(
    parameter int HASH_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bfws_pkg::in_item_t    s_item,
    input  logic                  init_done,
    input  logic                  q_full,
    output logic                  push,
    output bfws_pkg::op_t         push_op,
    output logic [HASH_BITS-1:0]  push_ha,
    output logic [HASH_BITS-1:0]  push_hb
);
    import bfws_pkg::*;

    localparam logic [HASH_BITS-1:0] SeedA = HASH_BITS'(SEED_A);
    localparam logic [HASH_BITS-1:0] SeedB = HASH_BITS'(SEED_B);

    logic [HASH_BITS-1:0] load_a_reg, load_a_next;
    logic [HASH_BITS-1:0] load_b_reg, load_b_next;
    logic [HASH_BITS-1:0] prev_a_reg, prev_a_next;
    logic [HASH_BITS-1:0] prev_b_reg, prev_b_next;
    logic [HASH_BITS-1:0] query_a_reg, query_a_next;
    logic [HASH_BITS-1:0] query_b_reg, query_b_next;
    logic                 cr_reg, cr_next;
    logic                 has_bytes_reg, has_bytes_next;

    logic [HASH_BITS-1:0] byte_ext;
    logic [HASH_BITS-1:0] load_a_step, load_b_step, query_a_step, query_b_step;

    assign s_ready = init_done && !q_full;
    assign push    = s_valid && s_ready;

    // One hash step per byte: h*33 + b and h*31 + b, wrapping at the index width
    assign byte_ext     = HASH_BITS'(s_item.byte_value);
    assign load_a_step  = (load_a_reg << 5) + load_a_reg + byte_ext;
    assign load_b_step  = (load_b_reg << 5) - load_b_reg + byte_ext;
    assign query_a_step = (query_a_reg << 5) + query_a_reg + byte_ext;
    assign query_b_step = (query_b_reg << 5) - query_b_reg + byte_ext;

    // Classify the item and work out the next line and query state
    always_comb begin
        load_a_next    = load_a_reg;
        load_b_next    = load_b_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        cr_next        = cr_reg;
        has_bytes_next = has_bytes_reg;
        query_a_next   = query_a_reg;
        query_b_next   = query_b_reg;
        push_op        = OP_NOP;
        push_ha        = load_a_reg;
        push_hb        = load_b_reg;
        case (s_item.kind)
            KIND_CLEAR: begin
                push_op        = OP_CLEAR;
                load_a_next    = SeedA;
                load_b_next    = SeedB;
                prev_a_next    = SeedA;
                prev_b_next    = SeedB;
                cr_next        = 1'b0;
                has_bytes_next = 1'b0;
            end
            KIND_LOAD: begin
                if (s_item.byte_value == BYTE_LF || s_item.last) begin
                    // end of line: an LF inserts unless empty, last alone inserts nothing; a trailing CR is left out
                    if (s_item.byte_value == BYTE_LF && has_bytes_reg) begin
                        push_op = OP_INSERT;
                        push_ha = cr_reg ? prev_a_reg : load_a_reg;
                        push_hb = cr_reg ? prev_b_reg : load_b_reg;
                    end
                    load_a_next    = SeedA;
                    load_b_next    = SeedB;
                    prev_a_next    = SeedA;
                    prev_b_next    = SeedB;
                    cr_next        = 1'b0;
                    has_bytes_next = 1'b0;
                end else begin
                    prev_a_next    = load_a_reg;
                    prev_b_next    = load_b_reg;
                    load_a_next    = load_a_step;
                    load_b_next    = load_b_step;
                    cr_next        = (s_item.byte_value == BYTE_CR);
                    has_bytes_next = 1'b1;
                end
            end
            KIND_LOOKUP: begin
                if (s_item.last) begin
                    push_op      = OP_LOOKUP;
                    push_ha      = query_a_step;
                    push_hb      = query_b_step;
                    query_a_next = SeedA;
                    query_b_next = SeedB;
                end else begin
                    query_a_next = query_a_step;
                    query_b_next = query_b_step;
                end
            end
            default: begin
            end
        endcase
    end

    // Line and query state, updated per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_a_reg    <= SeedA;
            load_b_reg    <= SeedB;
            prev_a_reg    <= SeedA;
            prev_b_reg    <= SeedB;
            cr_reg        <= 1'b0;
            has_bytes_reg <= 1'b0;
            query_a_reg   <= SeedA;
            query_b_reg   <= SeedB;
        end else if (push) begin
            load_a_reg    <= load_a_next;
            load_b_reg    <= load_b_next;
            prev_a_reg    <= prev_a_next;
            prev_b_reg    <= prev_b_next;
            cr_reg        <= cr_next;
            has_bytes_reg <= has_bytes_next;
            query_a_reg   <= query_a_next;
            query_b_reg   <= query_b_next;
        end
    end

endmodule

[design/bfws_queue.sv]
// Operation queue: small FIFO between the front and back parts.
module bfws_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full       = (fill_reg == CntW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping, wrapping at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/bfws_back.sv]
// Back part: bit store, word count, clearing sweep and result register.
module bfws_back #(
    parameter int HASH_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  bfws_pkg::op_t         q_op,
    input  logic [HASH_BITS-1:0]  q_ha,
    input  logic [HASH_BITS-1:0]  q_hb,
    output logic                  q_pop,
    output logic                  init_done,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bfws_pkg::out_item_t   m_item
);
    import bfws_pkg::*;

    localparam int Depth = 2 ** HASH_BITS;

    back_state_t          state_reg, state_next;
    logic [HASH_BITS-1:0] sweep_reg, sweep_next;
    logic [HASH_BITS-1:0] hb_hold_reg, hb_hold_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg;

    logic                 mem [Depth];
    logic                 rd_a_reg, rd_b_reg;

    logic                 out_free;
    logic                 sweep_done;
    logic                 mem_we;
    logic [HASH_BITS-1:0] mem_waddr;
    logic                 mem_wdata;
    logic                 rd_en;
    logic                 emit;
    out_item_t            emit_item;
    logic [COUNT_W-1:0]   count_inc;

    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_done = (sweep_reg == '1);
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign init_done  = (state_reg != ST_INIT);
    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    case (q_op)
                        OP_CLEAR:  state_next = ST_SWEEP;
                        OP_INSERT: state_next = ST_SET_B;
                        OP_LOOKUP: state_next = ST_LOOK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET_B: state_next = ST_IDLE;
            ST_LOOK: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Datapath controls and result generation
    always_comb begin
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = sweep_reg;
        mem_wdata    = 1'b0;
        rd_en        = 1'b0;
        emit         = 1'b0;
        sweep_next   = sweep_reg;
        hb_hold_next = hb_hold_reg;
        count_next   = count_reg;
        emit_item    = '{found: 1'b0, found_valid: 1'b0, word_count: count_reg};
        case (state_reg)
            ST_INIT, ST_SWEEP: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_op)
                        OP_CLEAR: begin
                            emit       = 1'b1;
                            count_next = '0;
                            emit_item.word_count = '0;
                        end
                        OP_INSERT: begin
                            emit         = 1'b1;
                            mem_we       = 1'b1;
                            mem_waddr    = q_ha;
                            mem_wdata    = 1'b1;
                            hb_hold_next = q_hb;
                            count_next   = count_inc;
                            emit_item.word_count = count_inc;
                        end
                        OP_LOOKUP: begin
                            rd_en = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SET_B: begin
                mem_we    = 1'b1;
                mem_waddr = hb_hold_reg;
                mem_wdata = 1'b1;
            end
            ST_LOOK: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_item.found       = rd_a_reg && rd_b_reg;
                    emit_item.found_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hb_hold_reg <= hb_hold_next;
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

    // Bit store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_a_reg <= mem[q_ha];
            rd_b_reg <= mem[q_hb];
        end
    end

endmodule

[design/bfws_checker.sv]
// Port-level checker for the bloom filter word set, bound to the top level.
`include "bloom_filter_word_set_defines.svh"

module bfws_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input bfws_pkg::in_item_t   s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input bfws_pkg::out_item_t  m_item
);
    import bfws_pkg::*;

    logic [COUNT_W-1:0] last_count_reg;
    logic               count_step_ok;

    // Word count of the most recent delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_count_reg <= m_item.word_count;
        end
    end

    // Count moves by a clear, by one insert, or not at all between results
    assign count_step_ok = (m_item.word_count == last_count_reg)
        || ({1'b0, m_item.word_count} == {1'b0, last_count_reg} + (COUNT_W + 1)'(1))
        || (m_item.word_count == '0);

    `BFWS_ASSERT_ALWAYS(a_reset_blocks_input, aclk, !aresetn |=> !s_ready && !m_valid, "input open or result shown right after reset")
    `BFWS_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "stalled result transaction changed")
    `BFWS_ASSERT(a_found_only_on_lookup, aclk, aresetn, m_valid && !m_item.found_valid |-> !m_item.found, "found set on a result that is not a lookup")
    `BFWS_ASSERT(a_count_step, aclk, aresetn, m_valid && m_ready |-> count_step_ok, "word count jumped between transactions")

endmodule

bind bloom_filter_word_set bfws_checker u_bfws_checker (.*);
